// ===== rtl/aabd_pkg.sv =====
// ----------------------------------------------------------------------------
// aabd_pkg
// Shared widths, register indexes and types of the activity boundary detector.
// ----------------------------------------------------------------------------
package aabd_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int MAG_BITS    = SAMPLE_BITS + 1;
   localparam int THRESH_BITS = 18;
   localparam int CHAN_BITS   = 2;
   localparam int OUT_BITS    = 32;

   // configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_THRESHOLD     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHANNEL_COUNT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BASE_INDEX    = 2'd2;

   localparam logic [THRESH_BITS-1:0] THRESHOLD_RESET     = 18'd200;
   localparam logic [CHAN_BITS-1:0]   CHANNEL_COUNT_RESET = 2'd1;

   // result queue
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;
   localparam int QUEUE_CNT_BITS = 3;

   typedef struct packed {
      logic valid;
      logic last;
      logic full;
      logic active;
   } stage_ctl_type;

   typedef struct packed {
      logic                found;
      logic [OUT_BITS-1:0] end_index;
      logic [OUT_BITS-1:0] start_index;
   } rsp_type;

endpackage

// ===== rtl/aabd_lane.sv =====
// ----------------------------------------------------------------------------
// aabd_lane
// One channel: magnitude, sliding window of magnitudes, running sum and
// threshold compare. The compare result is registered.
// ----------------------------------------------------------------------------
module aabd_lane #(
   parameter int WINDOW_LEN = 5
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   step,
   input  logic                                   clear,
   input  logic [aabd_pkg::SAMPLE_BITS-1:0]       sample,
   input  logic [aabd_pkg::THRESH_BITS-1:0]       threshold,
   output logic                                   active
);

   localparam int SUM_BITS = aabd_pkg::MAG_BITS + $clog2(WINDOW_LEN);
   localparam int CMP_BITS = (SUM_BITS > aabd_pkg::THRESH_BITS) ?
                             SUM_BITS : aabd_pkg::THRESH_BITS;
   localparam logic [aabd_pkg::MAG_BITS-1:0] MAG_FULL =
      {1'b1, {aabd_pkg::SAMPLE_BITS{1'b0}}};

   logic [aabd_pkg::MAG_BITS-1:0] hist_ff [WINDOW_LEN];
   logic [aabd_pkg::MAG_BITS-1:0] hist_in [WINDOW_LEN];
   logic [SUM_BITS-1:0]           sum_ff;
   logic [SUM_BITS-1:0]           sum_in;
   logic [SUM_BITS-1:0]           new_sum;
   logic [aabd_pkg::MAG_BITS-1:0] mag;
   logic                          active_ff;
   logic                          active_in;

   // two's complement magnitude; -32768 gives 32768
   assign mag = sample[aabd_pkg::SAMPLE_BITS-1] ? (MAG_FULL - {1'b0, sample})
                                                : {1'b0, sample};

   // oldest entry is part of the sum, so this never goes negative
   assign new_sum = sum_ff + SUM_BITS'(mag) - SUM_BITS'(hist_ff[WINDOW_LEN-1]);
   assign sum_in  = clear ? '0 : new_sum;
   assign active_in = CMP_BITS'(new_sum) > CMP_BITS'(threshold);

   always_comb begin
      for (int k = 0; k < WINDOW_LEN; k++) begin
         hist_in[k] = '0;
      end
      if (!clear) begin
         hist_in[0] = mag;
         for (int k = 1; k < WINDOW_LEN; k++) begin
            hist_in[k] = hist_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < WINDOW_LEN; k++) begin
            hist_ff[k] <= '0;
         end
         sum_ff <= '0;
      end else if (step) begin
         hist_ff <= hist_in;
         sum_ff  <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         active_ff <= active_in;
      end
   end

   assign active = active_ff;

endmodule

// ===== rtl/aabd_merge.sv =====
// ----------------------------------------------------------------------------
// aabd_merge
// Combines the lane flags of one frame, tracks the earliest start and latest
// end of the search and builds the report on the closing frame.
// ----------------------------------------------------------------------------
module aabd_merge #(
   parameter int INDEX_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  aabd_pkg::stage_ctl_type           ctl,
   input  logic [INDEX_BITS-1:0]             frame_idx,
   input  logic [INDEX_BITS-1:0]             start_cand,
   input  logic [aabd_pkg::OUT_BITS-1:0]     base_index,
   output logic                              push,
   output aabd_pkg::rsp_type                 result
);

   localparam int WIDE_BITS = ((INDEX_BITS > aabd_pkg::OUT_BITS) ?
                               INDEX_BITS : aabd_pkg::OUT_BITS) + 1;

   logic                  start_seen_ff, start_seen_in;
   logic [INDEX_BITS-1:0] start_pos_ff, start_pos_in;
   logic [INDEX_BITS-1:0] end_pos_ff, end_pos_in;
   logic                  hit;
   logic                  seen_fin;
   logic [INDEX_BITS-1:0] start_fin;
   logic [INDEX_BITS-1:0] end_fin;

   function automatic logic [aabd_pkg::OUT_BITS-1:0] offset_sat(
      input logic [aabd_pkg::OUT_BITS-1:0] base,
      input logic [INDEX_BITS-1:0]         pos
   );
      logic [WIDE_BITS-1:0] s;
      s = WIDE_BITS'(base) + WIDE_BITS'(pos);
      if (s[WIDE_BITS-1:aabd_pkg::OUT_BITS] != '0) begin
         return '1;
      end
      return s[aabd_pkg::OUT_BITS-1:0];
   endfunction

   assign hit = ctl.full && ctl.active;

   always_comb begin
      seen_fin  = start_seen_ff || hit;
      start_fin = (hit && !start_seen_ff) ? start_cand : start_pos_ff;
      end_fin   = hit ? frame_idx : end_pos_ff;
      // stream shorter than the window: partial sum decides
      if (ctl.last && !ctl.full && ctl.active) begin
         seen_fin  = 1'b1;
         start_fin = '0;
         end_fin   = frame_idx;
      end
   end

   always_comb begin
      start_seen_in = start_seen_ff;
      start_pos_in  = start_pos_ff;
      end_pos_in    = end_pos_ff;
      if (ctl.valid) begin
         if (ctl.last) begin
            start_seen_in = 1'b0;
            start_pos_in  = '0;
            end_pos_in    = '0;
         end else begin
            start_seen_in = seen_fin;
            start_pos_in  = start_fin;
            end_pos_in    = end_fin;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_seen_ff <= 1'b0;
         start_pos_ff  <= '0;
         end_pos_ff    <= '0;
      end else begin
         start_seen_ff <= start_seen_in;
         start_pos_ff  <= start_pos_in;
         end_pos_ff    <= end_pos_in;
      end
   end

   assign push               = ctl.valid && ctl.last;
   assign result.found       = seen_fin;
   assign result.start_index = seen_fin ? offset_sat(base_index, start_fin) : '0;
   assign result.end_index   = seen_fin ? offset_sat(base_index, end_fin) : '0;

endmodule

// ===== rtl/aabd_queue.sv =====
// ----------------------------------------------------------------------------
// aabd_queue
// Small result queue in front of the response channel.
// ----------------------------------------------------------------------------
module aabd_queue (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push,
   input  aabd_pkg::rsp_type                     push_data,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output aabd_pkg::rsp_type                     out_data,
   output logic [aabd_pkg::QUEUE_CNT_BITS-1:0]   level
);

   aabd_pkg::rsp_type entry_ff [aabd_pkg::QUEUE_DEPTH];

   logic [aabd_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [aabd_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [aabd_pkg::QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                                pop;

   assign pop = (count_ff != '0) && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign level     = count_ff;

endmodule

// ===== rtl/audio_activity_boundary_detector.sv =====
// ----------------------------------------------------------------------------
// audio_activity_boundary_detector
// Finds the first and last sample of audible data in a one or two channel
// stream of frames that hold 16-bit samples.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one frame per request: both channel samples in req_tdata,
//   req_tlast on the frame that closes the search range. Every closing frame
//   yields one response on rsp_*: start and end index in rsp_tdata and the
//   found flag in rsp_tuser (indexes are zero when nothing was found).
//   Throughput is one frame per cycle while req_tready is high; each lane
//   updates its window sum and registers its threshold compare. rsp_tvalid
//   rises at the clock edge after the one that accepts the closing frame.
//   Responses wait in a four-entry queue. req_tready drops only when the
//   queue plus the response in flight would fill it, so frames keep flowing
//   while a response waits on a stalled receiver.
//   csr_* writes threshold, channel count and base index; write them only
//   while no search is in progress. Reset returns the registers to their
//   defaults and empties the windows, search state and queue.
// ----------------------------------------------------------------------------
module audio_activity_boundary_detector #(
   parameter int WINDOW_LEN = 5,
   parameter int INDEX_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration
   input  logic                                  csr_we,
   input  logic [aabd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [aabd_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   // request channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [31:0]                           req_tdata,   // sample_ch0, sample_ch1
   input  logic                                  req_tlast,   // last_sample
   // response channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [63:0]                           rsp_tdata,   // start_index, end_index
   output logic                                  rsp_tuser    // found
);

   localparam logic [INDEX_BITS-1:0] FULL_AT = INDEX_BITS'(WINDOW_LEN - 1);

   logic [aabd_pkg::THRESH_BITS-1:0] threshold_ff;
   logic [aabd_pkg::CHAN_BITS-1:0]   channel_count_ff;
   logic [aabd_pkg::OUT_BITS-1:0]    base_index_ff;

   logic                  accept;
   logic [INDEX_BITS-1:0] frame_ff, frame_in;
   logic                  a_valid_ff;
   logic                  a_last_ff;
   logic                  a_full_ff;
   logic [INDEX_BITS-1:0] a_frame_ff;
   logic [INDEX_BITS-1:0] a_start_ff;
   logic                  act0, act1;

   aabd_pkg::stage_ctl_type ctl;
   aabd_pkg::rsp_type       result;
   aabd_pkg::rsp_type       rsp_data;
   logic                    push;
   logic [aabd_pkg::QUEUE_CNT_BITS-1:0] level;
   logic [aabd_pkg::QUEUE_CNT_BITS:0]   pending;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff     <= aabd_pkg::THRESHOLD_RESET;
         channel_count_ff <= aabd_pkg::CHANNEL_COUNT_RESET;
         base_index_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            aabd_pkg::CSR_THRESHOLD:
               threshold_ff <= csr_wdata[aabd_pkg::THRESH_BITS-1:0];
            aabd_pkg::CSR_CHANNEL_COUNT:
               channel_count_ff <= csr_wdata[aabd_pkg::CHAN_BITS-1:0];
            aabd_pkg::CSR_BASE_INDEX:
               base_index_ff <= csr_wdata[aabd_pkg::OUT_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign accept = req_tvalid && req_tready;

   // frame index within the search, saturating
   always_comb begin
      frame_in = frame_ff;
      if (accept) begin
         if (req_tlast) begin
            frame_in = '0;
         end else if (frame_ff != '1) begin
            frame_in = frame_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff   <= '0;
         a_valid_ff <= 1'b0;
      end else begin
         frame_ff   <= frame_in;
         a_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_last_ff  <= req_tlast;
         a_full_ff  <= (frame_ff >= FULL_AT);
         a_frame_ff <= frame_ff;
         a_start_ff <= frame_ff - FULL_AT;
      end
   end

   aabd_lane #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_lane0 (
      .clock     (clock),
      .reset     (reset),
      .step      (accept),
      .clear     (req_tlast),
      .sample    (req_tdata[15:0]),
      .threshold (threshold_ff),
      .active    (act0)
   );

   aabd_lane #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_lane1 (
      .clock     (clock),
      .reset     (reset),
      .step      (accept),
      .clear     (req_tlast),
      .sample    (req_tdata[31:16]),
      .threshold (threshold_ff),
      .active    (act1)
   );

   // channel count of 2 or 3 examines the second lane
   always_comb begin
      ctl.valid  = a_valid_ff;
      ctl.last   = a_last_ff;
      ctl.full   = a_full_ff;
      ctl.active = act0 || (channel_count_ff[1] && act1);
   end

   aabd_merge #(
      .INDEX_BITS (INDEX_BITS)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .frame_idx  (a_frame_ff),
      .start_cand (a_start_ff),
      .base_index (base_index_ff),
      .push       (push),
      .result     (result)
   );

   aabd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data),
      .level     (level)
   );

   // leave room for a response still in the merge stage
   assign pending    = {1'b0, level} +
                       {{aabd_pkg::QUEUE_CNT_BITS{1'b0}}, (a_valid_ff && a_last_ff)};
   assign req_tready = pending < (aabd_pkg::QUEUE_CNT_BITS + 1)'(aabd_pkg::QUEUE_DEPTH);

   assign rsp_tdata = {rsp_data.end_index, rsp_data.start_index};
   assign rsp_tuser = rsp_data.found;

endmodule

// ===== rtl/aabd_checker.sv =====
// ----------------------------------------------------------------------------
// aabd_checker
// Port-level checks of the activity boundary detector, bound to the top.
// ----------------------------------------------------------------------------
module aabd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tuser
);

   // nothing is pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // without a find both indexes read zero
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == 64'd0))
      else $error("nonzero indexes on a response without a find");

   // a found region never ends before it starts
   a_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[31:0] <= rsp_tdata[63:32]))
      else $error("start index beyond end index");

   // a stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled response changed");

   // a response rises only after a closing request went in; a closing
   // request accepted in the previous cycle is still in the merge stage
   a_cause: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !req_tlast && !rsp_tvalid &&
       !$past(req_tvalid && req_tready && req_tlast)) |=> !rsp_tvalid)
      else $error("response without a closing request");

endmodule

bind audio_activity_boundary_detector aabd_checker u_aabd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
